// File: rtl/core/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared widths, codes and controller/datapath interface types of the
// snapshot pose interpolator.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int TIME_BITS  = 48;
  localparam int POS_BITS   = 32;
  localparam int ANGLE_BITS = 16;
  localparam int ANIM_BITS  = 3;
  localparam int CFG_BITS   = 32;
  localparam int HALF_BITS  = 32;
  localparam int FRAC_BITS  = 2 * HALF_BITS;

  // numerator of the fraction: time difference plus one carry bit
  localparam int NUM_BITS    = TIME_BITS + 1;
  localparam int DIV_STEPS   = (NUM_BITS + HALF_BITS + 1) / 2;
  localparam int DVD_BITS    = 2 * DIV_STEPS;
  localparam int MAG_BITS    = POS_BITS + 1;
  localparam int PROD_BITS   = MAG_BITS + HALF_BITS;
  localparam int NUM_LANES   = 4;
  localparam int BLEND_STEPS = 2 * NUM_LANES + 1;
  localparam int CNT_BITS    = $clog2(DIV_STEPS);

  localparam logic [CFG_BITS-1:0] LAG_RESET   = CFG_BITS'(6554);
  localparam logic [CFG_BITS-1:0] EXTRA_RESET = CFG_BITS'(16384);

  typedef enum logic [0:0] {
    CFG_LAG   = 1'b0,
    CFG_EXTRA = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_ITEM  = 2'd0,
    SRC_NEWER = 2'd1,
    SRC_BLEND = 2'd2
  } out_src_e;

  typedef enum logic [1:0] {
    LANE_X   = 2'd0,
    LANE_Y   = 2'd1,
    LANE_Z   = 2'd2,
    LANE_YAW = 2'd3
  } lane_e;

  typedef struct packed {
    logic     capture;
    logic     decode;
    logic     push;
    logic     div_load;
    logic     div_step;
    logic     mul_issue;
    lane_e    lane;
    logic     half;
    logic     load_out;
    out_src_e src;
  } spi_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic empty;
    logic single;
  } spi_sts_t;

endpackage

// File: rtl/core/spi_ctrl.sv
// ----------------------------------------------------------------------------
// spi_ctrl
// Sequencer: steps one item through decode, fraction division, the shared
// multiplier passes and the output handoff.
// ----------------------------------------------------------------------------
module spi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  spi_pkg::spi_sts_t sts_i,
  output spi_pkg::spi_cmd_t cmd_o
);
  import spi_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_BLEND  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  out_src_e              src_q, src_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;
  logic                  out_free;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.src   = src_q;
    cmd_o.lane  = lane_e'(cnt_q[2:1]);
    cmd_o.half  = cnt_q[0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (!sts_i.is_sample) begin
          cmd_o.push = 1'b1;
          if (sts_i.empty) begin
            src_d   = SRC_ITEM;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.empty) begin
          state_d = ST_IDLE;
        end else if (sts_i.single) begin
          src_d   = SRC_NEWER;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_BLEND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_BLEND: begin
        // last count only drains the accumulate stage
        cmd_o.mul_issue = (cnt_q < CNT_BITS'(BLEND_STEPS - 1));
        if (cnt_q == CNT_BITS'(BLEND_STEPS - 1)) begin
          cnt_d   = '0;
          src_d   = SRC_BLEND;
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      src_q       <= SRC_ITEM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      src_q       <= src_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled beat");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DECODE))
    else $error("accepted beat not decoded");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DIVIDE) |-> (cnt_q == '0))
    else $error("divider started with stale count");

endmodule

// File: rtl/core/spi_dp.sv
// ----------------------------------------------------------------------------
// spi_dp
// Datapath: snapshot store, config registers, radix-4 fraction divider,
// shared 33x32 multiplier with accumulate and saturation, output registers.
// ----------------------------------------------------------------------------
module spi_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  spi_pkg::spi_cmd_t                     cmd_i,
  output spi_pkg::spi_sts_t                     sts_o,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [spi_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  logic                                  op_i,
  input  logic [spi_pkg::TIME_BITS-1:0]         event_time_i,
  input  logic signed [spi_pkg::POS_BITS-1:0]   pos_x_i,
  input  logic signed [spi_pkg::POS_BITS-1:0]   pos_y_i,
  input  logic signed [spi_pkg::POS_BITS-1:0]   pos_z_i,
  input  logic signed [spi_pkg::ANGLE_BITS-1:0] yaw_in_i,
  input  logic [spi_pkg::ANIM_BITS-1:0]         anim_in_i,
  output logic signed [spi_pkg::POS_BITS-1:0]   out_x_o,
  output logic signed [spi_pkg::POS_BITS-1:0]   out_y_o,
  output logic signed [spi_pkg::POS_BITS-1:0]   out_z_o,
  output logic signed [spi_pkg::ANGLE_BITS-1:0] out_yaw_o,
  output logic [spi_pkg::ANIM_BITS-1:0]         out_anim_o
);
  import spi_pkg::*;

  localparam int SUM_BITS = PROD_BITS + 3;

  logic [CFG_BITS-1:0]   lag_q, extra_q;

  logic                  op_q;
  logic [TIME_BITS-1:0]  it_time_q;
  logic [POS_BITS-1:0]   it_x_q, it_y_q, it_z_q;
  logic [ANGLE_BITS-1:0] it_yaw_q;
  logic [ANIM_BITS-1:0]  it_anim_q;

  logic [1:0]            count_q;
  logic [TIME_BITS-1:0]  snap_t_q   [2];
  logic [POS_BITS-1:0]   snap_x_q   [2];
  logic [POS_BITS-1:0]   snap_y_q   [2];
  logic [POS_BITS-1:0]   snap_z_q   [2];
  logic [ANGLE_BITS-1:0] snap_yaw_q [2];
  logic [ANIM_BITS-1:0]  snap_anim_q[2];

  logic [TIME_BITS-1:0]  d_q;
  logic [NUM_BITS-1:0]   tl_q;
  logic [DVD_BITS-1:0]   dvd_q, dvd_d;
  logic [TIME_BITS-1:0]  rem_q, rem_d;
  logic [FRAC_BITS-1:0]  quo_q, quo_d;
  logic                  ovf_q, ovf_d;

  logic [PROD_BITS-1:0]  mul_q;
  lane_e                 lane_q;
  logic                  half_q;
  logic                  acc_v_q;
  logic [MAG_BITS-1:0]   lo_q;
  logic [POS_BITS-1:0]   res_pos_q [3];
  logic [ANGLE_BITS-1:0] res_yaw_q;

  // fraction preparation
  logic [TIME_BITS-1:0]  n_raw;
  logic                  n_pos;
  logic [NUM_BITS-1:0]   n_lim, n_val;

  // blend signals
  logic [FRAC_BITS-1:0]  frac, frac_yaw, frac_sel;
  logic [MAG_BITS-1:0]   diff_x, diff_y, diff_z;
  logic [ANGLE_BITS-1:0] diff_yaw, mag_yaw;
  logic [MAG_BITS-1:0]   mag [NUM_LANES];
  logic                  neg [NUM_LANES];
  logic [MAG_BITS-1:0]   mag_sel;
  logic [HALF_BITS-1:0]  f_half;
  logic [PROD_BITS:0]    r_sum;
  logic signed [SUM_BITS-1:0] a_ext, off, s_sum;
  logic [POS_BITS-1:0]   a_sel, pos_sat;
  logic [ANGLE_BITS-1:0] yaw_new;

  assign sts_o.is_sample = op_q;
  assign sts_o.empty     = (count_q == 2'd0);
  assign sts_o.single    = (count_q == 2'd1) || (snap_t_q[1] <= snap_t_q[0]);

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q   <= LAG_RESET;
      extra_q <= EXTRA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LAG:   lag_q   <= cfg_data_i;
        CFG_EXTRA: extra_q <= cfg_data_i;
        default:   lag_q   <= lag_q;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      it_time_q <= event_time_i;
      it_x_q    <= pos_x_i;
      it_y_q    <= pos_y_i;
      it_z_q    <= pos_z_i;
      it_yaw_q  <= yaw_in_i;
      it_anim_q <= anim_in_i;
    end
  end

  // snapshot store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (cmd_i.push) begin
      if (count_q == 2'd0) begin
        count_q <= 2'd1;
      end else if (it_time_q > snap_t_q[1]) begin
        count_q <= 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if (count_q == 2'd0 || it_time_q > snap_t_q[1]) begin
        // first push fills both entries, a newer one ages the newest
        snap_t_q[0]    <= (count_q == 2'd0) ? it_time_q : snap_t_q[1];
        snap_x_q[0]    <= (count_q == 2'd0) ? it_x_q    : snap_x_q[1];
        snap_y_q[0]    <= (count_q == 2'd0) ? it_y_q    : snap_y_q[1];
        snap_z_q[0]    <= (count_q == 2'd0) ? it_z_q    : snap_z_q[1];
        snap_yaw_q[0]  <= (count_q == 2'd0) ? it_yaw_q  : snap_yaw_q[1];
        snap_anim_q[0] <= (count_q == 2'd0) ? it_anim_q : snap_anim_q[1];
      end
      snap_t_q[1]    <= it_time_q;
      snap_x_q[1]    <= it_x_q;
      snap_y_q[1]    <= it_y_q;
      snap_z_q[1]    <= it_z_q;
      snap_yaw_q[1]  <= it_yaw_q;
      snap_anim_q[1] <= it_anim_q;
    end
  end

  // fraction numerator and divider
  assign n_raw = tl_q[TIME_BITS-1:0] - snap_t_q[0];
  assign n_pos = !tl_q[TIME_BITS] && (tl_q[TIME_BITS-1:0] > snap_t_q[0]);
  assign n_lim = {1'b0, d_q} + NUM_BITS'(extra_q);
  always_comb begin
    n_val = n_pos ? {1'b0, n_raw} : '0;
    if (n_val > n_lim) begin
      n_val = n_lim;
    end
  end

  always_comb begin
    logic [NUM_BITS-1:0] t;
    dvd_d = dvd_q;
    rem_d = rem_q;
    quo_d = quo_q;
    ovf_d = ovf_q;
    for (int i = 0; i < 2; i++) begin
      t     = {rem_d, dvd_d[DVD_BITS-1]};
      dvd_d = {dvd_d[DVD_BITS-2:0], 1'b0};
      ovf_d = ovf_d | quo_d[FRAC_BITS-1];
      if (t >= {1'b0, d_q}) begin
        t     = t - {1'b0, d_q};
        quo_d = {quo_d[FRAC_BITS-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[FRAC_BITS-2:0], 1'b0};
      end
      rem_d = t[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      d_q  <= snap_t_q[1] - snap_t_q[0];
      tl_q <= {1'b0, it_time_q} - NUM_BITS'(lag_q);
    end
    if (cmd_i.div_load) begin
      dvd_q <= {{(DVD_BITS - NUM_BITS - HALF_BITS){1'b0}}, n_val, {HALF_BITS{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  // blend operands
  assign frac     = ovf_q ? '1 : quo_q;
  assign frac_yaw = (frac > (FRAC_BITS'(1) << HALF_BITS)) ?
                    (FRAC_BITS'(1) << HALF_BITS) : frac;

  assign diff_x   = MAG_BITS'(signed'(snap_x_q[1])) - MAG_BITS'(signed'(snap_x_q[0]));
  assign diff_y   = MAG_BITS'(signed'(snap_y_q[1])) - MAG_BITS'(signed'(snap_y_q[0]));
  assign diff_z   = MAG_BITS'(signed'(snap_z_q[1])) - MAG_BITS'(signed'(snap_z_q[0]));
  assign diff_yaw = snap_yaw_q[1] - snap_yaw_q[0];
  assign mag_yaw  = diff_yaw[ANGLE_BITS-1] ? (~diff_yaw + 1'b1) : diff_yaw;

  assign neg[LANE_X]   = diff_x[MAG_BITS-1];
  assign neg[LANE_Y]   = diff_y[MAG_BITS-1];
  assign neg[LANE_Z]   = diff_z[MAG_BITS-1];
  assign neg[LANE_YAW] = diff_yaw[ANGLE_BITS-1];
  assign mag[LANE_X]   = diff_x[MAG_BITS-1] ? (~diff_x + 1'b1) : diff_x;
  assign mag[LANE_Y]   = diff_y[MAG_BITS-1] ? (~diff_y + 1'b1) : diff_y;
  assign mag[LANE_Z]   = diff_z[MAG_BITS-1] ? (~diff_z + 1'b1) : diff_z;
  assign mag[LANE_YAW] = MAG_BITS'(mag_yaw);

  assign mag_sel  = mag[cmd_i.lane];
  assign frac_sel = (cmd_i.lane == LANE_YAW) ? frac_yaw : frac;
  assign f_half   = cmd_i.half ? frac_sel[FRAC_BITS-1:HALF_BITS] : frac_sel[HALF_BITS-1:0];

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_issue) begin
      mul_q  <= PROD_BITS'(mag_sel) * PROD_BITS'(f_half);
      lane_q <= cmd_i.lane;
      half_q <= cmd_i.half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.mul_issue;
    end
  end

  // accumulate, apply sign, saturate
  assign r_sum = {1'b0, mul_q} + (PROD_BITS + 1)'(lo_q);

  always_comb begin
    case (lane_q)
      LANE_X:  a_sel = snap_x_q[0];
      LANE_Y:  a_sel = snap_y_q[0];
      default: a_sel = snap_z_q[0];
    endcase
  end

  assign a_ext = SUM_BITS'(signed'(a_sel));
  assign off   = neg[lane_q] ? -signed'(SUM_BITS'(r_sum)) : signed'(SUM_BITS'(r_sum));
  assign s_sum = a_ext + off;

  always_comb begin
    if (s_sum > SUM_BITS'(signed'({1'b0, {(POS_BITS-1){1'b1}}}))) begin
      pos_sat = {1'b0, {(POS_BITS-1){1'b1}}};
    end else if (s_sum < SUM_BITS'(signed'({1'b1, {(POS_BITS-1){1'b0}}}))) begin
      pos_sat = {1'b1, {(POS_BITS-1){1'b0}}};
    end else begin
      pos_sat = s_sum[POS_BITS-1:0];
    end
  end

  assign yaw_new = neg[LANE_YAW] ? (snap_yaw_q[0] - r_sum[ANGLE_BITS-1:0])
                                 : (snap_yaw_q[0] + r_sum[ANGLE_BITS-1:0]);

  always_ff @(posedge clk_i) begin
    if (acc_v_q) begin
      if (!half_q) begin
        lo_q <= mul_q[PROD_BITS-1:HALF_BITS];
      end else begin
        case (lane_q)
          LANE_X:   res_pos_q[0] <= pos_sat;
          LANE_Y:   res_pos_q[1] <= pos_sat;
          LANE_Z:   res_pos_q[2] <= pos_sat;
          default:  res_yaw_q    <= yaw_new;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.src)
        SRC_ITEM: begin
          out_x_o    <= it_x_q;
          out_y_o    <= it_y_q;
          out_z_o    <= it_z_q;
          out_yaw_o  <= it_yaw_q;
          out_anim_o <= it_anim_q;
        end
        SRC_BLEND: begin
          out_x_o    <= res_pos_q[0];
          out_y_o    <= res_pos_q[1];
          out_z_o    <= res_pos_q[2];
          out_yaw_o  <= res_yaw_q;
          // switch to the newer code from fraction one half on
          out_anim_o <= (|frac[FRAC_BITS-1:HALF_BITS-1]) ? snap_anim_q[1] : snap_anim_q[0];
        end
        default: begin
          out_x_o    <= snap_x_q[1];
          out_y_o    <= snap_y_q[1];
          out_z_o    <= snap_z_q[1];
          out_yaw_o  <= snap_yaw_q[1];
          out_anim_o <= snap_anim_q[1];
        end
      endcase
    end
  end

endmodule

// File: rtl/core/snapshot_pose_interpolator.sv
// ----------------------------------------------------------------------------
// snapshot_pose_interpolator
// Two-snapshot pose interpolator with lag, bounded extrapolation and
// short-way yaw blending.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per push
//   (op_i = 0) or sample (op_i = 1). Output channel (out_valid_o /
//   out_stall_i) carries a pose for the first push and for each sample
//   once a snapshot exists; other beats give no pose.
//   One item is in flight at a time; in_stall_o is low only while idle.
//   Push: capture, then decode; the first push also passes the emit state
//   to the output register. A sample with one usable snapshot passes
//   capture, decode and emit. An interpolating sample passes capture,
//   decode, prep, the divider (two quotient bits per cycle over 82 bits)
//   and four lanes through one shared multiplier, two passes each.
//   A finished pose waits in the output register; the block returns to
//   idle and takes the next beat while the receiver stalls, and holds a
//   second pose only until that register frees.
//   Reset clears the snapshot count, the output valid and loads the
//   default lag and extrapolation limit. Write config only while idle.
// ----------------------------------------------------------------------------
module snapshot_pose_interpolator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  op_i,
  input  logic [spi_pkg::TIME_BITS-1:0]         event_time_i,
  input  logic signed [spi_pkg::POS_BITS-1:0]   pos_x_i,
  input  logic signed [spi_pkg::POS_BITS-1:0]   pos_y_i,
  input  logic signed [spi_pkg::POS_BITS-1:0]   pos_z_i,
  input  logic signed [spi_pkg::ANGLE_BITS-1:0] yaw_in_i,
  input  logic [spi_pkg::ANIM_BITS-1:0]         anim_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [spi_pkg::POS_BITS-1:0]   out_x_o,
  output logic signed [spi_pkg::POS_BITS-1:0]   out_y_o,
  output logic signed [spi_pkg::POS_BITS-1:0]   out_z_o,
  output logic signed [spi_pkg::ANGLE_BITS-1:0] out_yaw_o,
  output logic [spi_pkg::ANIM_BITS-1:0]         out_anim_o,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [spi_pkg::CFG_BITS-1:0]          cfg_data_i
);
  import spi_pkg::*;

  spi_cmd_t cmd;
  spi_sts_t sts;

  spi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .event_time_i (event_time_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .yaw_in_i     (yaw_in_i),
    .anim_in_i    (anim_in_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_yaw_o    (out_yaw_o),
    .out_anim_o   (out_anim_o)
  );

endmodule

// File: bench/snapshot_pose_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snapshot_pose_interpolator_tb
// Self-checking bench: drives pushes and samples with random gaps, predicts
// each pose from a local model of the two-snapshot store, compares in order.
// ----------------------------------------------------------------------------
module snapshot_pose_interpolator_tb;
  import spi_pkg::*;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam longint unsigned CYCLE_LIMIT = 600000;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] MAG_CAP = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [POS_BITS-1:0]   x;
    logic signed [POS_BITS-1:0]   y;
    logic signed [POS_BITS-1:0]   z;
    logic signed [ANGLE_BITS-1:0] yaw;
    logic [ANIM_BITS-1:0]         anim;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = 1'b0;
  logic [TIME_BITS-1:0] event_time_i = '0;
  logic signed [POS_BITS-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [ANGLE_BITS-1:0] yaw_in_i = '0;
  logic [ANIM_BITS-1:0] anim_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [POS_BITS-1:0] out_x_o, out_y_o, out_z_o;
  logic signed [ANGLE_BITS-1:0] out_yaw_o;
  logic [ANIM_BITS-1:0] out_anim_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;

  snapshot_pose_interpolator uut (.*);

  always #5 clk_i = ~clk_i;

  // local copy of configuration and snapshot store
  logic [CFG_BITS-1:0] lag_q, extra_q;
  int unsigned snap_cnt;
  logic [TIME_BITS-1:0] st_time [2];
  pose_t st_pose [2];

  pose_t expected_poses[$];
  int unsigned errors = 0;
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  bit stall_on = 1'b1;

  function automatic logic [63:0] scale_q32(logic [63:0] mag, logic [63:0] f);
    logic [127:0] p;
    p = mag * f;
    if (p[127:94] != 0) return MAG_CAP;
    return (p[95:32] > MAG_CAP) ? MAG_CAP : p[95:32];
  endfunction

  function automatic logic [POS_BITS-1:0] lerp_pos(logic signed [POS_BITS-1:0] a,
                                                    logic signed [POS_BITS-1:0] b,
                                                    logic [63:0] f);
    longint signed diff, s;
    logic [63:0] m;
    diff = longint'(b) - longint'(a);
    m = scale_q32(diff < 0 ? -diff : diff, f);
    s = longint'(a) + (diff < 0 ? -longint'(m) : longint'(m));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[POS_BITS-1:0];
  endfunction

  function automatic logic [ANGLE_BITS-1:0] lerp_yaw(logic [ANGLE_BITS-1:0] a,
                                                      logic [ANGLE_BITS-1:0] b,
                                                      logic [63:0] f);
    logic signed [ANGLE_BITS-1:0] diff;
    logic [63:0] m;
    diff = b - a;
    m = scale_q32(diff < 0 ? 64'(-longint'(diff)) : 64'(diff), f);
    return diff < 0 ? a - m[ANGLE_BITS-1:0] : a + m[ANGLE_BITS-1:0];
  endfunction

  // advance the snapshot store by one beat; returns 1 with a pose when one is due
  function automatic bit predict_pose(logic op, logic [TIME_BITS-1:0] now, pose_t item,
                                      output pose_t pose);
    logic [63:0] d, n, lim, f, fy;
    logic [127:0] q;
    pose = item;
    if (op == OP_PUSH) begin
      if (snap_cnt == 0) begin
        st_time[0] = now; st_time[1] = now;
        st_pose[0] = item; st_pose[1] = item;
        snap_cnt = 1;
        return 1'b1;
      end
      if (now > st_time[1]) begin
        st_time[0] = st_time[1];
        st_pose[0] = st_pose[1];
        snap_cnt = 2;
      end
      st_time[1] = now;
      st_pose[1] = item;
      return 1'b0;
    end
    if (snap_cnt == 0) return 1'b0;
    if (snap_cnt == 1 || st_time[1] <= st_time[0]) begin
      pose = st_pose[1];
      return 1'b1;
    end
    d = st_time[1] - st_time[0];
    n = 0;
    if (now >= lag_q && now - lag_q > st_time[0]) n = now - lag_q - st_time[0];
    lim = d + extra_q;
    if (n > lim) n = lim;
    q = {n, 32'h0} / d;
    f = (q[127:64] != 0) ? '1 : q[63:0];
    fy = f > ONE_Q32 ? ONE_Q32 : f;
    pose.x = lerp_pos(st_pose[0].x, st_pose[1].x, f);
    pose.y = lerp_pos(st_pose[0].y, st_pose[1].y, f);
    pose.z = lerp_pos(st_pose[0].z, st_pose[1].z, f);
    pose.yaw = lerp_yaw(st_pose[0].yaw, st_pose[1].yaw, fy);
    pose.anim = f >= 64'h8000_0000 ? st_pose[1].anim : st_pose[0].anim;
    return 1'b1;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // called at a falling edge; leaves valid high after the accepting edge
  task automatic send_beat(logic op, logic [TIME_BITS-1:0] t, pose_t p);
    pose_t pose;
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i <= op; event_time_i <= t;
    pos_x_i <= p.x; pos_y_i <= p.y; pos_z_i <= p.z;
    yaw_in_i <= p.yaw; anim_in_i <= p.anim;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_pose(op, t, p, pose)) expected_poses.insert(expected_poses.size(), pose);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_poses.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_BITS-1:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LAG) lag_q = v; else extra_q = v;
    @(negedge clk_i);
  endtask

  function automatic pose_t rand_pose(bit wild);
    pose_t p;
    p.x = wild ? $urandom : POS_BITS'($urandom_range(0, 200000) - 100000);
    p.y = wild ? $urandom : POS_BITS'($urandom_range(0, 200000) - 100000);
    p.z = $urandom;
    p.yaw = ANGLE_BITS'($urandom);
    p.anim = wild ? ANIM_BITS'($urandom_range(0, 7)) : ANIM_BITS'($urandom_range(0, 4));
    return p;
  endfunction

  // output side: random stall, in-order compare
  always @(negedge clk_i) begin
    if (stall_on) out_stall_i <= ($urandom_range(0, 99) < 30) ||
                                 ($urandom_range(0, 99) < 2 && out_stall_i);
    else out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    pose_t got, want;
    cycles <= cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      got = '{out_x_o, out_y_o, out_z_o, out_yaw_o, out_anim_o};
      if (expected_poses.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose %h", got);
      end else begin
        want = expected_poses.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("pose mismatch: exp x=%h y=%h z=%h yaw=%h anim=%0d",
                     want.x, want.y, want.z, want.yaw, want.anim);
            $display("               got x=%h y=%h z=%h yaw=%h anim=%0d",
                     got.x, got.y, got.z, got.yaw, got.anim);
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    pose_t p;
    p = '{32'sh7fffffff, -32'sh80000000, 0, -16'sh8000, 3'd7};
    send_beat(OP_SAMPLE, 48'd100, p);
    send_beat(OP_PUSH, 48'h0, p);
    send_beat(OP_SAMPLE, 48'hffff_ffff_ffff, p);
    send_beat(OP_PUSH, 48'h0, '{-32'sh80000000, 32'sh7fffffff, 5, 16'sh7fff, 3'd0});
    send_beat(OP_SAMPLE, 48'd0, p);
    send_beat(OP_PUSH, 48'h10000, '{32'sh7fffffff, -32'sh80000000, -5, 16'sh7fff, 3'd4});
    send_beat(OP_SAMPLE, 48'h0, p);
    send_beat(OP_SAMPLE, 48'h8000 + 6554, p);
    send_beat(OP_SAMPLE, 48'h10000 + 6554, p);
    send_beat(OP_SAMPLE, 48'hffff_ffff_ffff, p);
    // exact half-turn yaw step
    send_beat(OP_PUSH, 48'h20000, '{0, 0, 0, -16'sh8000, 3'd2});
    send_beat(OP_PUSH, 48'h30000, '{1, 1, 1, 16'sh0000, 3'd5});
    send_beat(OP_SAMPLE, 48'h28000 + 6554, p);
    send_beat(OP_SAMPLE, 48'h27fff + 6554, p);
    // stale push replaces the newest
    send_beat(OP_PUSH, 48'h10000, '{7, 8, 9, 16'sh1234, 3'd1});
    send_beat(OP_SAMPLE, 48'h40000, p);
    send_beat(OP_PUSH, 48'hffff_ffff_ffff, rand_pose(1));
    send_beat(OP_SAMPLE, 48'hffff_ffff_ffff, p);
    drain();
  endtask

  task automatic test_random(int unsigned items);
    logic [TIME_BITS-1:0] t;
    int unsigned k;
    t = {16'h0, $urandom};
    for (k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        t = t + $urandom_range(0, 12000);
        if ($urandom_range(0, 5) == 0)
          send_beat(OP_PUSH, t, rand_pose($urandom_range(0, 3) == 0));
        else
          send_beat(OP_SAMPLE, t + $urandom_range(0, 40000), rand_pose(1));
      end else begin
        send_beat(1'($urandom_range(0, 1)), TIME_BITS'({$urandom, $urandom}),
                  rand_pose(1));
      end
      if (k == items / 2) drain();
    end
    drain();
  endtask

  initial begin
    lag_q = LAG_RESET; extra_q = EXTRA_RESET;
    snap_cnt = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    write_reg(CFG_LAG, 32'd0);
    write_reg(CFG_EXTRA, 32'd0);
    test_random(130);
    write_reg(CFG_LAG, 32'hffff_ffff);
    write_reg(CFG_EXTRA, 32'hffff_ffff);
    test_random(130);
    stall_on = 1'b0;
    write_reg(CFG_LAG, $urandom_range(0, 20000));
    write_reg(CFG_EXTRA, $urandom_range(0, 60000));
    test_random(130);
    stall_on = 1'b1;
    write_reg(CFG_LAG, LAG_RESET);
    write_reg(CFG_EXTRA, EXTRA_RESET);
    test_random(140);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: snapshot_pose_interpolator.f
rtl/core/spi_pkg.sv
rtl/core/spi_ctrl.sv
rtl/core/spi_dp.sv
rtl/core/snapshot_pose_interpolator.sv
bench/snapshot_pose_interpolator_tb.sv
